// ===== sv/dotc_pkg.sv =====
package dotc_pkg;

  localparam int ID_W   = 20;
  localparam int OFF_W  = 17;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 5;
  localparam int WIG_W  = 8;

  localparam logic [WIG_W-1:0] WIGGLE_RESET = 8'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_MERGED   = 3'd0,
    KIND_APPENDED = 3'd1,
    KIND_DROPPED  = 3'd2,
    KIND_DRAINED  = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] low;
    logic [OFF_W-1:0] high;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] low;
    logic [OFF_W-1:0] high;
  } cmp_res_t;

endpackage

// ===== sv/dotc_mem.sv =====
module dotc_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  dotc_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output dotc_pkg::entry_t  rdata
);
  import dotc_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dotc_cmp.sv =====
module dotc_cmp (
  input  dotc_pkg::entry_t                ent,
  input  logic [dotc_pkg::ID_W-1:0]       id,
  input  logic [dotc_pkg::OFF_W-1:0]      off,
  input  logic [dotc_pkg::WIG_W-1:0]      wiggle,
  output dotc_pkg::cmp_res_t              res
);
  import dotc_pkg::*;

  localparam int XW = OFF_W + 2;

  logic signed [XW-1:0] lo_x;
  logic signed [XW-1:0] hi_x;
  logic signed [XW-1:0] off_x;
  logic signed [XW-1:0] wig_x;

  // widened window [low - wiggle, high + wiggle], no wrap at 19 bits
  always_comb begin
    wig_x = $signed({{(XW-WIG_W){1'b0}}, wiggle});
    off_x = $signed({{(XW-OFF_W){off[OFF_W-1]}}, off});
    lo_x  = $signed({{(XW-OFF_W){ent.low[OFF_W-1]}}, ent.low}) - wig_x;
    hi_x  = $signed({{(XW-OFF_W){ent.high[OFF_W-1]}}, ent.high}) + wig_x;
    res.hit  = (ent.id == id) && (lo_x <= off_x) && (hi_x >= off_x);
    res.low  = ($signed(off) < $signed(ent.low))  ? off : ent.low;
    res.high = ($signed(off) > $signed(ent.high)) ? off : ent.high;
  end

endmodule

// ===== sv/diagonal_offset_cluster_table_unit.sv =====
// Offset cluster table.
// Input channel (in_valid/in_ready): action 0 inserts (read_id, position_offset),
// action 1 drains the table. Each insert gives one result: merged into the first
// matching cluster, appended as a new cluster, or dropped when the table is full.
// A drain gives one result per stored cluster in insertion order, last set on the
// final one, then empties the table; a drain of an empty table gives one
// table-empty result.
// Config channel (cfg_valid/cfg_data): writes the 8-bit match tolerance (wiggle),
// always ready; write only while no transaction is in flight.
// An insert scans the stored entries in order, visiting at least one, one at a time
// through the single table read port and the one shared window compare. A drain
// emits one entry per cycle through the same read port while results are taken.
// The input is accepted only while the sequencer is idle; one transaction at a
// time. Results sit in an output register; while the receiver stalls the
// sequencer holds its place and the table read is repeated.
// Reset (rst_n low, synchronous) empties the table and sets wiggle to 3; the table
// storage itself is not cleared, so no clearing pass is needed.
module diagonal_offset_cluster_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [dotc_pkg::ID_W-1:0]       in_read_id,
  input  logic signed [dotc_pkg::OFF_W-1:0] in_position_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dotc_pkg::KIND_W-1:0]     out_kind,
  output logic [dotc_pkg::SLOT_W-1:0]     out_slot,
  output logic [dotc_pkg::ID_W-1:0]       out_entry_read_id,
  output logic signed [dotc_pkg::OFF_W-1:0] out_entry_low,
  output logic signed [dotc_pkg::OFF_W-1:0] out_entry_high,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dotc_pkg::WIG_W-1:0]      cfg_data
);
  import dotc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WIG_W-1:0]  wiggle_r;
  logic [ID_W-1:0]   in_id_r;
  logic [OFF_W-1:0]  in_off_r;

  kind_t             res_kind_r, res_kind_nxt;
  logic [IW-1:0]     res_slot_r, res_slot_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [OFF_W-1:0]  res_low_r, res_low_nxt;
  logic [OFF_W-1:0]  res_high_r, res_high_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [OFF_W-1:0]  out_low_r, out_low_nxt;
  logic [OFF_W-1:0]  out_high_r, out_high_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [IW-1:0]     rd_addr;
  entry_t            rdata;
  cmp_res_t          cmp_res;

  logic              out_free;
  logic              hit;
  logic              at_end;
  logic              full;
  logic              drain_last;
  logic              out_load;
  logic [IW-1:0]     slot_src;
  logic [SW-1:0]     slot_wide;

  dotc_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  dotc_cmp u_cmp (
    .ent    (rdata),
    .id     (in_id_r),
    .off    (in_off_r),
    .wiggle (wiggle_r),
    .res    (cmp_res)
  );

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    hit        = (count_r != '0) && cmp_res.hit;
    drain_last = (CW'(idx_r) + CW'(1)) == count_r;
    at_end     = (count_r == '0) || drain_last;
    full       = count_r == CW'(TABLE_DEPTH);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_DRAIN) begin
            state_nxt = (count_r == '0) ? ST_EMIT : ST_DRAIN;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (hit || at_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free && drain_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CHECK: begin
        mem_we  = hit || (at_end && !full);
        rd_addr = idx_r + IW'(1);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_DRAIN: begin
        out_load = out_free;
        rd_addr  = out_free ? idx_r + IW'(1) : idx_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_waddr = hit ? idx_r : count_r[IW-1:0];
    mem_wdata.id   = in_id_r;
    mem_wdata.low  = hit ? cmp_res.low  : in_off_r;
    mem_wdata.high = hit ? cmp_res.high : in_off_r;
  end

  // datapath next values
  always_comb begin
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    res_kind_nxt = res_kind_r;
    res_slot_nxt = res_slot_r;
    res_id_nxt   = res_id_r;
    res_low_nxt  = res_low_r;
    res_high_nxt = res_high_r;

    case (state_r)
      ST_IDLE: begin
        idx_nxt      = '0;
        res_kind_nxt = KIND_EMPTY;
        res_slot_nxt = '0;
        res_id_nxt   = '0;
        res_low_nxt  = '0;
        res_high_nxt = '0;
      end
      ST_CHECK: begin
        res_id_nxt = in_id_r;
        if (hit) begin
          res_kind_nxt = KIND_MERGED;
          res_slot_nxt = idx_r;
          res_low_nxt  = cmp_res.low;
          res_high_nxt = cmp_res.high;
        end else if (at_end) begin
          res_low_nxt  = in_off_r;
          res_high_nxt = in_off_r;
          if (full) begin
            res_kind_nxt = KIND_DROPPED;
            res_slot_nxt = '0;
          end else begin
            res_kind_nxt = KIND_APPENDED;
            res_slot_nxt = count_r[IW-1:0];
            count_nxt    = count_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          if (drain_last) begin
            count_nxt = '0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // output register
  always_comb begin
    slot_src  = (state_r == ST_DRAIN) ? idx_r : res_slot_r;
    slot_wide = SW'(slot_src);

    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_id_nxt    = out_id_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = slot_wide[SLOT_W-1:0];
      if (state_r == ST_DRAIN) begin
        out_kind_nxt = KIND_DRAINED;
        out_id_nxt   = rdata.id;
        out_low_nxt  = rdata.low;
        out_high_nxt = rdata.high;
        out_last_nxt = drain_last;
      end else begin
        out_kind_nxt = res_kind_r;
        out_id_nxt   = res_id_r;
        out_low_nxt  = res_low_r;
        out_high_nxt = res_high_r;
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      wiggle_r    <= WIGGLE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        wiggle_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_id_r  <= in_read_id;
      in_off_r <= in_position_offset;
    end
    res_kind_r <= res_kind_nxt;
    res_slot_r <= res_slot_nxt;
    res_id_r   <= res_id_nxt;
    res_low_r  <= res_low_nxt;
    res_high_r <= res_high_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_id_r   <= out_id_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
    out_last_r <= out_last_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_slot          = out_slot_r;
  assign out_entry_read_id = out_id_r;
  assign out_entry_low     = out_low_r;
  assign out_entry_high    = out_high_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_DRAIN) |->
      (count_r == '0 || CW'(idx_r) < count_r))
    else $error("scan index beyond stored entries");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && out_free && drain_last) |=> (count_r == '0))
    else $error("table not empty after drain");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT || $past(state_r) == ST_DRAIN))
    else $error("result raised outside emit or drain");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CHECK && (hit || !full)))
    else $error("table write outside scan decision");
`endif

endmodule
